/* hw/rtl/assert_macros.svh */
// assertion macros for the rtl, compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define RMT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("assertion failed");
`define RMT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition");
`else
`define RMT_ASSERT(lbl, clk, rstn, prop)
`define RMT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

/* hw/rtl/rmt_pkg.sv */
package rmt_pkg;

  localparam int WINDOW     = 5;
  localparam int DATA_W     = 16;
  localparam int POS_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int RND_W      = $clog2(WINDOW + 1);
  localparam int MID        = WINDOW / 2;
  localparam int RESET_TEMP = 200;

  typedef logic signed [DATA_W-1:0] temp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SORT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic sort;
    logic parity;
    logic capture;
  } cmd_t;

endpackage

/* hw/rtl/running_median_temperature.sv */
// running median of temperature readings over a five-entry window
// input channel: in_valid / in_ready / in_sample, signed tenths of a degree
// output channel: out_valid / out_ready / out_median, one result per request
// each request overwrites the oldest window entry, the window is sorted by
// an odd-even transposition network (one phase per cycle, WINDOW phases)
// and the middle entry is registered as the result
// out_valid rises as the middle entry is captured into the output register
// a new request is taken only after the last result has left the sort buffer
// in_ready is high only in S_IDLE, not while a request is sorted or waits for capture
// the output register holds a finished result while the receiver stalls;
// a new request may be taken and sorted meanwhile, and its result waits in
// the sort buffer until the output register is drained
// reset (rst_n low, synchronous) fills every window entry with 200 (20.0
// degrees), clears the write position and drops out_valid
module running_median_temperature (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rmt_pkg::temp_t       in_sample,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rmt_pkg::temp_t       out_median
);

  rmt_pkg::cmd_t cmd;

  rmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  rmt_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_sample  (in_sample),
    .out_median (out_median)
  );

endmodule

/* hw/rtl/rmt_ctrl.sv */
`include "assert_macros.svh"

module rmt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output rmt_pkg::cmd_t cmd
);

  rmt_pkg::state_t           state_r, state_nxt;
  logic [rmt_pkg::RND_W-1:0] rnd_r, rnd_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      last_rnd;

  assign last_rnd  = (rnd_r == rmt_pkg::RND_W'(rmt_pkg::WINDOW - 1));
  assign in_ready  = (state_r == rmt_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rmt_pkg::S_IDLE;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    rnd_nxt     = rnd_r;
    cmd         = '0;
    cmd.parity  = rnd_r[0];
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    unique case (state_r)
      rmt_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          rnd_nxt   = '0;
          state_nxt = rmt_pkg::S_SORT;
        end
      end
      rmt_pkg::S_SORT: begin
        cmd.sort = 1'b1;
        rnd_nxt  = rnd_r + 1'b1;
        if (last_rnd) begin
          state_nxt = rmt_pkg::S_DONE;
        end
      end
      rmt_pkg::S_DONE: begin
        // output register free or being drained
        if (!out_valid_r || out_ready) begin
          cmd.capture   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = rmt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rmt_pkg::S_IDLE;
      end
    endcase
  end

  `RMT_ASSERT(a_accept_starts_sort, clk, rst_n,
    (in_valid && in_ready) |=> (state_r == rmt_pkg::S_SORT && rnd_r == '0))
  `RMT_NEVER(a_no_overwrite, clk, rst_n, cmd.capture && out_valid_r && !out_ready)
  `RMT_ASSERT(a_sort_ends_done, clk, rst_n,
    (state_r == rmt_pkg::S_SORT && last_rnd) |=> (state_r == rmt_pkg::S_DONE))

endmodule

/* hw/rtl/rmt_dp.sv */
module rmt_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  rmt_pkg::cmd_t       cmd,
  input  rmt_pkg::temp_t      in_sample,
  output rmt_pkg::temp_t      out_median
);

  rmt_pkg::temp_t            win_r [rmt_pkg::WINDOW];
  rmt_pkg::temp_t            srt_r [rmt_pkg::WINDOW];
  rmt_pkg::temp_t            srt_nxt [rmt_pkg::WINDOW];
  rmt_pkg::temp_t            med_r;
  logic [rmt_pkg::POS_W-1:0] pos_r, pos_nxt;

  assign pos_nxt = (pos_r == rmt_pkg::POS_W'(rmt_pkg::WINDOW - 1)) ? '0 : pos_r + 1'b1;

  // window and write position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rmt_pkg::WINDOW; i++) begin
        win_r[i] <= rmt_pkg::temp_t'(rmt_pkg::RESET_TEMP);
      end
      pos_r <= '0;
    end else if (cmd.load) begin
      win_r[pos_r] <= in_sample;
      pos_r        <= pos_nxt;
    end
  end

  // sort buffer: loaded from the window with the new sample, then odd-even transposition sort, one phase per cycle
  always_comb begin
    for (int i = 0; i < rmt_pkg::WINDOW; i++) begin
      srt_nxt[i] = srt_r[i];
    end
    if (cmd.load) begin
      for (int i = 0; i < rmt_pkg::WINDOW; i++) begin
        srt_nxt[i] = (pos_r == rmt_pkg::POS_W'(i)) ? in_sample : win_r[i];
      end
    end else if (cmd.sort) begin
      for (int i = 0; i < rmt_pkg::WINDOW - 1; i++) begin
        if ((1'(i) == cmd.parity) && (srt_r[i] > srt_r[i+1])) begin
          srt_nxt[i]   = srt_r[i+1];
          srt_nxt[i+1] = srt_r[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < rmt_pkg::WINDOW; i++) begin
      srt_r[i] <= srt_nxt[i];
    end
    if (cmd.capture) begin
      med_r <= srt_r[rmt_pkg::MID];
    end
  end

  assign out_median = med_r;

endmodule
